// ===== design/nsd_pkg.sv =====
// Shared widths, codes, the query token type and a constant helper for the seed distance block.
package nsd_pkg;

    localparam int POS_W      = 8;
    localparam int IDX_W      = 4;
    localparam int CFG_W      = 5;
    localparam int CNT_W      = 9;
    localparam int SQ_W       = 17;
    localparam int DIST_W     = 9;
    localparam int SQRT_STEPS = 9;

    localparam int NUM_SEEDS_DEF    = 16;
    localparam int IMAGE_WIDTH_DEF  = 256;
    localparam int IMAGE_HEIGHT_DEF = 256;

    localparam logic [CFG_W-1:0] SEEDS_RESET = CFG_W'(16);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // A query as it travels down the cell row.
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic             seen;
        logic [SQ_W-1:0]  min_sq;
    } t_token;

    // Floor of the square root, evaluated at elaboration only.
    function automatic int isqrt_const(input int value);
        int v;
        int root;
        int bitv;
        v    = value;
        root = 0;
        bitv = 1 << 30;
        while (bitv > v) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

endpackage

// ===== design/nsd_cell.sv =====
// One seed cell: stores a seed and folds its squared distance into the passing query.
module nsd_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [nsd_pkg::IDX_W-1:0]     i_load_index,
    input  logic [nsd_pkg::POS_W-1:0]     i_load_x,
    input  logic [nsd_pkg::POS_W-1:0]     i_load_y,
    input  logic [nsd_pkg::CNT_W-1:0]     i_count,
    input  nsd_pkg::t_token               i_token,
    output nsd_pkg::t_token               o_token
);

    localparam bit Addressable = (CELL_INDEX < (1 << nsd_pkg::IDX_W));

    logic [nsd_pkg::POS_W-1:0]   r_seed_x;
    logic [nsd_pkg::POS_W-1:0]   r_seed_y;
    nsd_pkg::t_token             r_token;
    nsd_pkg::t_token             n_token;
    logic [nsd_pkg::POS_W-1:0]   w_dx;
    logic [nsd_pkg::POS_W-1:0]   w_dy;
    logic [2*nsd_pkg::POS_W-1:0] w_dx2;
    logic [2*nsd_pkg::POS_W-1:0] w_dy2;
    logic [nsd_pkg::SQ_W-1:0]    w_sum;
    logic                        w_in_use;

    always_ff @(posedge i_clk) begin
        if (Addressable && i_load &&
            (i_load_index == nsd_pkg::IDX_W'(CELL_INDEX))) begin
            r_seed_x <= i_load_x;
            r_seed_y <= i_load_y;
        end
    end

    always_comb begin
        w_dx     = (r_seed_x > i_token.px) ? (r_seed_x - i_token.px) : (i_token.px - r_seed_x);
        w_dy     = (r_seed_y > i_token.py) ? (r_seed_y - i_token.py) : (i_token.py - r_seed_y);
        w_dx2    = w_dx * w_dx;
        w_dy2    = w_dy * w_dy;
        w_sum    = nsd_pkg::SQ_W'(w_dx2) + nsd_pkg::SQ_W'(w_dy2);
        w_in_use = (nsd_pkg::CNT_W'(CELL_INDEX) < i_count);
        n_token  = i_token;
        if (w_in_use && (!i_token.seen || (w_sum < i_token.min_sq))) begin
            n_token.seen   = 1'b1;
            n_token.min_sq = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token.valid <= 1'b0;
        end else begin
            r_token.valid <= n_token.valid;
        end
        r_token.px     <= n_token.px;
        r_token.py     <= n_token.py;
        r_token.seen   <= n_token.seen;
        r_token.min_sq <= n_token.min_sq;
    end

    assign o_token = r_token;

endmodule

// ===== design/nsd_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module nsd_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [nsd_pkg::SQ_W-1:0]     i_radicand,
    output logic                         o_done,
    output logic [nsd_pkg::DIST_W-1:0]   o_root
);

    localparam int RadW  = 2 * nsd_pkg::SQRT_STEPS;
    localparam int RemW  = nsd_pkg::DIST_W + 1;
    localparam int CntW  = $clog2(nsd_pkg::SQRT_STEPS);
    localparam logic [CntW-1:0] LastStep = CntW'(nsd_pkg::SQRT_STEPS - 1);

    logic                        r_active;
    logic                        r_done;
    logic [CntW-1:0]             r_count;
    logic [RadW-1:0]             r_rad;
    logic [RemW-1:0]             r_rem;
    logic [nsd_pkg::DIST_W-1:0]  r_root;
    logic [RemW+1:0]             w_shifted;
    logic [RemW+1:0]             w_trial;
    logic                        w_fits;

    always_comb begin
        w_shifted = {r_rem, r_rad[RadW-1 -: 2]};
        w_trial   = {1'b0, r_root, 2'b01};
        w_fits    = (w_shifted >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_count  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_count  <= '0;
            end else if (r_active) begin
                r_count <= r_count + 1'b1;
                if (r_count == LastStep) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RadW'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_active) begin
            r_rad <= {r_rad[RadW-3:0], 2'b00};
            if (w_fits) begin
                r_rem  <= RemW'(w_shifted - w_trial);
                r_root <= {r_root[nsd_pkg::DIST_W-2:0], 1'b1};
            end else begin
                r_rem  <= RemW'(w_shifted);
                r_root <= {r_root[nsd_pkg::DIST_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== design/nearest_seed_distance.sv =====
// Top level of the nearest seed distance block: seed row, square root unit and command port.
//
// The block keeps a row of NUM_SEEDS seed cells. A load word (command 0) writes
// seed_index's cell; a load whose slot has no cell is dropped. A query word
// (command 1) enters the head of the cell row and moves one cell per clock; every
// cell in use (its slot below seeds_in_use, clamped to NUM_SEEDS) folds in the
// squared distance from its seed to the pixel, keeping the smallest one. The floor
// square root of that minimum is then taken by an iterative unit, two radicand
// bits per cycle, and the result is capped at floor(sqrt(IMAGE_WIDTH^2 +
// IMAGE_HEIGHT^2)), itself saturated at 511. With no seeds in use the cap is
// returned. A query word's result appears on o_distance with o_result_strobe high
// for exactly one cycle, after the query has passed through the cell row, the
// square root unit and the output register. busy stays high from the query until
// that result cycle, in which a new word may already be taken, so a new query is
// taken only once the last one's result shows. There is no way to hold a result
// off: the receiver must take it in its strobe cycle. The seeds_in_use register
// is written through its own valid/ready channel, which is always ready; it
// should only be changed while busy is low. Reading a seed that was never loaded
// gives an undefined distance.
module nearest_seed_distance #(
    parameter int NUM_SEEDS    = nsd_pkg::NUM_SEEDS_DEF,
    parameter int IMAGE_WIDTH  = nsd_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = nsd_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  logic [nsd_pkg::IDX_W-1:0]     i_seed_index,
    input  logic [nsd_pkg::POS_W-1:0]     i_pos_x,
    input  logic [nsd_pkg::POS_W-1:0]     i_pos_y,
    output logic                          o_result_strobe,
    output logic [nsd_pkg::DIST_W-1:0]    o_distance,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nsd_pkg::CFG_W-1:0]     i_cfg_data
);

    // The cap is a constant of the image size; saturate it to the result width.
    localparam int CapRoot = nsd_pkg::isqrt_const(IMAGE_WIDTH * IMAGE_WIDTH +
                                                  IMAGE_HEIGHT * IMAGE_HEIGHT);
    localparam int DistMax = (1 << nsd_pkg::DIST_W) - 1;
    localparam logic [nsd_pkg::DIST_W-1:0] CapSat =
        (CapRoot > DistMax) ? nsd_pkg::DIST_W'(DistMax) : nsd_pkg::DIST_W'(CapRoot);

    logic [nsd_pkg::CFG_W-1:0]   r_seeds_in_use;
    logic                        r_busy;
    logic                        r_strobe;
    logic [nsd_pkg::DIST_W-1:0]  r_distance;
    logic                        r_seen;
    logic [nsd_pkg::DIST_W-1:0]  n_distance;
    logic [nsd_pkg::CNT_W-1:0]   w_count;
    logic                        w_accept;
    logic                        w_load;
    logic                        w_query;
    logic                        w_sqrt_done;
    logic [nsd_pkg::DIST_W-1:0]  w_root;
    nsd_pkg::t_token             w_chain [NUM_SEEDS+1];
    logic [NUM_SEEDS:0]          w_chain_valid;

    assign w_accept = start && !r_busy;
    assign w_load   = w_accept && (i_command == nsd_pkg::CMD_LOAD);
    assign w_query  = w_accept && (i_command == nsd_pkg::CMD_QUERY);

    // The register is always writable; the user must only write it while idle, which the block does not enforce.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeds_in_use <= nsd_pkg::SEEDS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seeds_in_use <= i_cfg_data;
        end
    end

    // Seeds compared per query, never more than there are cells.
    always_comb begin
        if (nsd_pkg::CNT_W'(r_seeds_in_use) > nsd_pkg::CNT_W'(NUM_SEEDS)) begin
            w_count = nsd_pkg::CNT_W'(NUM_SEEDS);
        end else begin
            w_count = nsd_pkg::CNT_W'(r_seeds_in_use);
        end
    end

    // A query enters the row carrying no candidate yet.
    always_comb begin
        w_chain[0].valid  = w_query;
        w_chain[0].px     = i_pos_x;
        w_chain[0].py     = i_pos_y;
        w_chain[0].seen   = 1'b0;
        w_chain[0].min_sq = '0;
    end

    for (genvar g = 0; g < NUM_SEEDS; g++) begin : g_cell
        nsd_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (w_load),
            .i_load_index (i_seed_index),
            .i_load_x     (i_pos_x),
            .i_load_y     (i_pos_y),
            .i_count      (w_count),
            .i_token      (w_chain[g]),
            .o_token      (w_chain[g+1])
        );
    end

    for (genvar v = 0; v <= NUM_SEEDS; v++) begin : g_valid
        assign w_chain_valid[v] = w_chain[v].valid;
    end

    // The minimum squared distance leaves the row and goes to the square root unit.
    nsd_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_chain[NUM_SEEDS].valid),
        .i_radicand (w_chain[NUM_SEEDS].min_sq),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_chain[NUM_SEEDS].valid) begin
            r_seen <= w_chain[NUM_SEEDS].seen;
        end
    end

    // Floor square root is monotonic, so the root of the minimum is the minimum root.
    always_comb begin
        if (r_seen && (w_root < CapSat)) begin
            n_distance = w_root;
        end else begin
            n_distance = CapSat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_sqrt_done;
            if (w_query) begin
                r_busy <= 1'b1;
            end else if (w_sqrt_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sqrt_done) begin
            r_distance <= n_distance;
        end
    end

    assign busy            = r_busy;
    assign o_result_strobe = r_strobe;
    assign o_distance      = r_distance;

    // A result only closes a query that was in flight, and the port is free when it shows.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_busy))
        else $error("result strobe without a query in flight");

    a_strobe_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !r_busy)
        else $error("busy still high in the result cycle");

    a_query_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query |=> r_busy)
        else $error("query taken but busy not raised");

    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_chain_valid[NUM_SEEDS:1]) <= 1)
        else $error("more than one query in the cell row");

    a_row_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_chain_valid[NUM_SEEDS:1] != '0) |-> r_busy)
        else $error("query token in the row while idle");

endmodule
